// ===== design/imu_pkg.sv =====
`timescale 1ns / 1ps

package imu_pkg;

	// Lattice geometry. LATTICE_WIDTH must be a power of two: the column is
	// the low bits of the site index and the row is the rest.
	localparam int LATTICE_WIDTH  = 64;
	localparam int LATTICE_HEIGHT = 64;
	localparam int SITE_COUNT     = LATTICE_WIDTH * LATTICE_HEIGHT;

	localparam int COL_BITS   = $clog2(LATTICE_WIDTH);
	localparam int ROW_BITS   = $clog2(LATTICE_HEIGHT);
	localparam int SITE_CNT_W = $clog2(SITE_COUNT + 1);

	// Field widths.
	localparam int SITE_W     = 12;
	localparam int RND_W      = 32;
	localparam int ENERGY_W   = 15;
	localparam int SPIN_SUM_W = 14;
	localparam int MAG_W      = 13;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// Request codes.
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_TRIAL = 1'b1;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TH_DE4 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TH_DE8 = CFG_IDX_W'(1);

	// Reset values of the running totals.
	localparam logic signed [ENERGY_W-1:0]   ENERGY_RST = ENERGY_W'(-2 * SITE_COUNT);
	localparam logic signed [SPIN_SUM_W-1:0] SPIN_RST   = SPIN_SUM_W'(SITE_COUNT);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_UP,
		ST_RD_DN,
		ST_RD_ROW,
		ST_FIN
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;    // latch the accepted request
		logic rd_up;      // read the row above
		logic rd_dn;      // read the row below, take the up neighbor
		logic rd_row;     // read the own row, take the down neighbor
		logic finish;     // decide, write back, update totals, load result
		logic clear_step; // write one all-ones row of the reset sweep
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic site_ok;    // latched site lies inside the lattice
		logic clear_last; // sweep is writing its last row
		logic out_free;   // result register can take a new result
	} status_t;

endpackage

// ===== design/imu_if.sv =====
`timescale 1ns / 1ps

interface imu_req_if import imu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [SITE_W-1:0] site_index;
	logic              spin_value;
	logic [RND_W-1:0]  random_fraction;

	modport source (output valid, req_type, site_index, spin_value, random_fraction,
		input ready);
	modport sink (input valid, req_type, site_index, spin_value, random_fraction,
		output ready);
endinterface

interface imu_res_if import imu_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       flip_taken;
	logic signed [ENERGY_W-1:0] energy_total;
	logic [MAG_W-1:0]           magnetization_abs;

	modport source (output valid, flip_taken, energy_total, magnetization_abs,
		input ready);
	modport sink (input valid, flip_taken, energy_total, magnetization_abs,
		output ready);
endinterface

interface imu_cfg_if import imu_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== design/ising_metropolis_update.sv =====
`timescale 1ns / 1ps

// Channel  Role   Handshake      Payload
// req      sink   valid / ready  req_type, site_index, spin_value, random_fraction
// res      source valid / ready  flip_taken, energy_total, magnetization_abs
// cfg      sink   valid / ready  reg_index, wdata (ready is always high)
//
// An item goes through accept, then reads of the row above, the row below and the
// own row through the single read port of the lattice memory, then decide.
// After reset a sweep writes all-ones rows, one row a cycle, over all LATTICE_HEIGHT
// rows (64); no item is accepted until it ends.
// A result waits in the output register; the decision cycle stalls only while
// that register is still full and not taken.

module ising_metropolis_update import imu_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	imu_req_if.sink  req,
	imu_res_if.source res,
	imu_cfg_if.sink  cfg
);

	cmd_t    cmd;
	status_t status;

	// Configuration writes land whenever they come; thresholds only matter
	// in the decision cycle.
	assign cfg.ready = 1'b1;

	imu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	imu_datapath u_datapath (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.status                (status),
		.req_type              (req.req_type),
		.site_index            (req.site_index),
		.spin_value            (req.spin_value),
		.random_fraction       (req.random_fraction),
		.cfg_we                (cfg.valid && cfg.ready),
		.cfg_index             (cfg.reg_index),
		.cfg_wdata             (cfg.wdata),
		.res_valid             (res.valid),
		.res_ready             (res.ready),
		.res_flip_taken        (res.flip_taken),
		.res_energy_total      (res.energy_total),
		.res_magnetization_abs (res.magnetization_abs)
	);

	// An accepted transaction starts the row reads unless the site is outside.
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (cmd.rd_up == status.site_ok))
		else $error("accepted transaction did not start the lattice reads");

	// Never overwrite a result that has not been taken.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> status.out_free)
		else $error("result register overwritten");

	// Every decision produces a result next cycle.
	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> res.valid)
		else $error("decision without result");

	// No transaction is accepted during the reset sweep.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step |-> !req.ready)
		else $error("request accepted during lattice sweep");

endmodule

// ===== design/imu_ctrl.sv =====
`timescale 1ns / 1ps

module imu_ctrl import imu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) begin
					state_nxt = ST_RD_UP;
				end
			end
			ST_RD_UP: begin
				// skip the reads for a site outside the lattice
				if (status.site_ok) begin
					cmd.rd_up = 1'b1;
					state_nxt = ST_RD_DN;
				end else begin
					state_nxt = ST_FIN;
				end
			end
			ST_RD_DN: begin
				cmd.rd_dn = 1'b1;
				state_nxt = ST_RD_ROW;
			end
			ST_RD_ROW: begin
				cmd.rd_row = 1'b1;
				state_nxt  = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/imu_datapath.sv =====
`timescale 1ns / 1ps

module imu_datapath import imu_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output status_t                    status,
	input  logic                       req_type,
	input  logic [SITE_W-1:0]          site_index,
	input  logic                       spin_value,
	input  logic [RND_W-1:0]           random_fraction,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_wdata,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic                       res_flip_taken,
	output logic signed [ENERGY_W-1:0] res_energy_total,
	output logic [MAG_W-1:0]           res_magnetization_abs
);

	// latched request
	logic              req_type_q;
	logic [SITE_W-1:0] site_q;
	logic              spin_q;
	logic [RND_W-1:0]  rnd_q;

	logic [RND_W-1:0] th_de4_q, th_de8_q;

	logic [COL_BITS-1:0] col, col_l, col_r;
	logic [ROW_BITS-1:0] row, row_up, row_dn;

	// lattice, one row per word
	logic [LATTICE_WIDTH-1:0] lattice_mem [LATTICE_HEIGHT];
	logic [LATTICE_WIDTH-1:0] rd_data_q;
	logic [ROW_BITS-1:0]      rd_addr, wr_addr;
	logic [LATTICE_WIDTH-1:0] wr_data;
	logic                     rd_en, wr_en;
	logic [ROW_BITS-1:0]      clr_cnt_q;

	logic up_bit_q, dn_bit_q;
	logic self_bit, left_bit, right_bit;
	logic [2:0]        up_count;
	logic [5:0]        kx4;
	logic signed [5:0] delta_e;
	logic              take, flip;

	logic signed [ENERGY_W-1:0]   energy_q, energy_nxt;
	logic signed [SPIN_SUM_W-1:0] spin_sum_q, spin_sum_nxt, spin_abs;
	logic                         res_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req_type;
			site_q     <= site_index;
			spin_q     <= spin_value;
			rnd_q      <= random_fraction;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_de4_q <= '0;
			th_de8_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_TH_DE4) begin
				th_de4_q <= cfg_wdata;
			end
			if (cfg_index == REG_TH_DE8) begin
				th_de8_q <= cfg_wdata;
			end
		end
	end

	// site geometry with periodic wrap
	assign col    = site_q[COL_BITS-1:0];
	assign row    = ROW_BITS'(site_q >> COL_BITS);
	assign col_l  = (col == '0) ? COL_BITS'(LATTICE_WIDTH - 1) : col - 1'b1;
	assign col_r  = (col == COL_BITS'(LATTICE_WIDTH - 1)) ? '0 : col + 1'b1;
	assign row_up = (row == '0) ? ROW_BITS'(LATTICE_HEIGHT - 1) : row - 1'b1;
	assign row_dn = (row == ROW_BITS'(LATTICE_HEIGHT - 1)) ? '0 : row + 1'b1;

	assign status.site_ok    = {1'b0, site_q} < SITE_CNT_W'(SITE_COUNT);
	assign status.clear_last = (clr_cnt_q == ROW_BITS'(LATTICE_HEIGHT - 1));
	assign status.out_free   = !res_valid_q || res_ready;

	// memory ports
	assign rd_en   = cmd.rd_up || cmd.rd_dn || cmd.rd_row;
	assign rd_addr = cmd.rd_up ? row_up : (cmd.rd_dn ? row_dn : row);
	assign wr_en   = cmd.clear_step || (cmd.finish && flip);
	assign wr_addr = cmd.clear_step ? clr_cnt_q : row;
	assign wr_data = cmd.clear_step ? '1
		: (rd_data_q ^ (LATTICE_WIDTH'(1) << col));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lattice_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= lattice_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_step) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// read data arrives in the cycle after its address
	always_ff @(posedge clk) begin
		if (cmd.rd_dn) begin
			up_bit_q <= rd_data_q[col];
		end
		if (cmd.rd_row) begin
			dn_bit_q <= rd_data_q[col];
		end
	end

	assign self_bit  = rd_data_q[col];
	assign left_bit  = rd_data_q[col_l];
	assign right_bit = rd_data_q[col_r];
	assign up_count  = 3'(up_bit_q) + 3'(dn_bit_q) + 3'(left_bit) + 3'(right_bit);

	// neighbor sum is 2k-4, so dE = +-(4k-8)
	assign kx4     = {1'b0, up_count, 2'b00};
	assign delta_e = self_bit ? ($signed(kx4) - 6'sd8) : (6'sd8 - $signed(kx4));

	always_comb begin
		if (req_type_q == REQ_LOAD) begin
			take = (self_bit != spin_q);
		end else if (delta_e[5] || delta_e == 6'sd0) begin
			take = 1'b1;
		end else if (delta_e == 6'sd4) begin
			take = rnd_q < th_de4_q;
		end else begin
			take = rnd_q < th_de8_q;
		end
	end

	assign flip = status.site_ok && take;

	assign energy_nxt   = flip ? energy_q + ENERGY_W'(delta_e) : energy_q;
	assign spin_sum_nxt = !flip ? spin_sum_q
		: (self_bit ? spin_sum_q - SPIN_SUM_W'(2) : spin_sum_q + SPIN_SUM_W'(2));
	assign spin_abs     = spin_sum_nxt[SPIN_SUM_W-1] ? -spin_sum_nxt : spin_sum_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q    <= ENERGY_RST;
			spin_sum_q  <= SPIN_RST;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				energy_q    <= energy_nxt;
				spin_sum_q  <= spin_sum_nxt;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_flip_taken        <= flip;
			res_energy_total      <= energy_nxt;
			res_magnetization_abs <= spin_abs[MAG_W-1:0];
		end
	end

	assign res_valid = res_valid_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench import imu_pkg::*; ();

	// Register indexes past the last real register: writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = {CFG_IDX_W{1'b1}};

	// Cycles without any transaction before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles to let pass after the last result before touching registers or ending.
	localparam int SETTLE_CYCLES  = 12;

	typedef struct packed {
		logic              req_type;
		logic [SITE_W-1:0] site_index;
		logic              spin_value;
		logic [RND_W-1:0]  random_fraction;
	} spin_request_t;

	typedef struct packed {
		logic                       flip_taken;
		logic signed [ENERGY_W-1:0] energy_total;
		logic [MAG_W-1:0]           magnetization_abs;
	} spin_update_t;

	logic clk;
	logic arst_n;

	imu_req_if req_ch ();
	imu_res_if res_ch ();
	imu_cfg_if cfg_ch ();

	ising_metropolis_update i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Shadow copy of the lattice, the running totals and the thresholds.
	logic            lattice_model [SITE_COUNT];
	int              energy_model;
	int              spin_total_model;
	logic [RND_W-1:0] th_de4_model;
	logic [RND_W-1:0] th_de8_model;

	spin_request_t pending_requests [$];
	spin_update_t  expected_updates [$];

	spin_request_t req_current;
	bit            req_loaded;
	bit            req_fired;
	int            req_gap;
	bit            res_fired;
	int            res_wait;
	bit            idle_off;
	int            fail_count;
	int            quiet_cycles;

	function automatic int spin_of_site(input int s);
		return lattice_model[s] ? 1 : -1;
	endfunction

	// Apply one request to the shadow lattice and return the result it must produce.
	function automatic spin_update_t predict_update(input spin_request_t rq);
		spin_update_t upd;
		int site;
		int row;
		int col;
		int nsum;
		int own;
		int delta_e;
		bit take;
		site = rq.site_index;
		take = 1'b0;
		if (site < SITE_COUNT) begin
			col = site % LATTICE_WIDTH;
			row = site / LATTICE_WIDTH;
			// Neighbors wrap around on both axes.
			nsum = spin_of_site(((row + LATTICE_HEIGHT - 1) % LATTICE_HEIGHT) * LATTICE_WIDTH + col)
				+ spin_of_site(((row + 1) % LATTICE_HEIGHT) * LATTICE_WIDTH + col)
				+ spin_of_site(row * LATTICE_WIDTH + (col + LATTICE_WIDTH - 1) % LATTICE_WIDTH)
				+ spin_of_site(row * LATTICE_WIDTH + (col + 1) % LATTICE_WIDTH);
			own = spin_of_site(site);
			delta_e = 2 * own * nsum;
			if (rq.req_type == REQ_LOAD) begin
				// A load of a differing spin acts as a forced flip.
				take = (lattice_model[site] != rq.spin_value);
			end else if (delta_e <= 0) begin
				take = 1'b1;
			end else if (delta_e == 4) begin
				take = (rq.random_fraction < th_de4_model);
			end else begin
				take = (rq.random_fraction < th_de8_model);
			end
			if (take) begin
				lattice_model[site] = ~lattice_model[site];
				energy_model += delta_e;
				spin_total_model -= 2 * own;
			end
		end
		upd.flip_taken        = take;
		upd.energy_total      = ENERGY_W'(energy_model);
		upd.magnetization_abs = MAG_W'(spin_total_model < 0 ? -spin_total_model : spin_total_model);
		return upd;
	endfunction

	// Wait cycles for one transaction; at least a quarter of draws are zero to keep bursts coming.
	function automatic int draw_wait();
		if (idle_off)
			return 0;
		return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 19));
	endfunction

	// Mostly trials; half the sites land in a 4x4 block that straddles both wraps.
	function automatic spin_request_t random_request(input logic [RND_W-1:0] th4,
			input logic [RND_W-1:0] th8);
		spin_request_t rq;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
		rq.req_type   = ($urandom_range(0, 4) == 0) ? REQ_LOAD : REQ_TRIAL;
		rq.spin_value = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 1)) begin
			rq.site_index = SITE_W'($urandom);
		end else begin
			col = COL_BITS'(int'($urandom_range(0, 3)) - 2);
			row = ROW_BITS'(int'($urandom_range(0, 3)) - 2);
			rq.site_index = SITE_W'({row, col});
		end
		case ($urandom_range(0, 3))
			0: rq.random_fraction = $urandom;
			// Straddle each threshold: one below, equal, one above.
			1: rq.random_fraction = th4 + RND_W'($urandom_range(0, 2)) - RND_W'(1);
			2: rq.random_fraction = th8 + RND_W'($urandom_range(0, 2)) - RND_W'(1);
			default: rq.random_fraction = $urandom_range(0, 1) ? '0 : '1;
		endcase
		return rq;
	endfunction

	task automatic push_request(input logic kind, input logic [SITE_W-1:0] site,
			input logic spin, input logic [RND_W-1:0] rnd);
		spin_request_t rq;
		rq.req_type        = kind;
		rq.site_index      = site;
		rq.spin_value      = spin;
		rq.random_fraction = rnd;
		pending_requests.push_back(rq);
	endtask

	// Hold until every queued request is through and every result is back, then settle.
	task automatic drain_and_settle();
		while (pending_requests.size() != 0 || req_loaded || expected_updates.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata     <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_TH_DE4: th_de4_model = data;
			REG_TH_DE8: th_de8_model = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [RND_W-1:0] th4, input logic [RND_W-1:0] th8,
			input int count, input bit steady);
		drain_and_settle();
		write_register(REG_TH_DE4, th4);
		write_register(REG_TH_DE8, th8);
		idle_off = steady;
		repeat (count) pending_requests.push_back(random_request(th4, th8));
	endtask

	// Request driver: take the next item, wait its gap, hold valid until the transaction.
	always @(negedge clk) begin
		logic next_valid;
		next_valid = 1'b0;
		if (req_fired) begin
			req_fired  = 1'b0;
			req_loaded = 1'b0;
		end
		if (arst_n && !req_loaded && pending_requests.size() != 0) begin
			req_current = pending_requests.pop_front();
			req_gap     = draw_wait();
			req_loaded  = 1'b1;
		end
		if (req_loaded) begin
			if (req_gap > 0)
				req_gap--;
			else
				next_valid = 1'b1;
		end
		req_ch.valid           <= next_valid;
		req_ch.req_type        <= req_current.req_type;
		req_ch.site_index      <= req_current.site_index;
		req_ch.spin_value      <= req_current.spin_value;
		req_ch.random_fraction <= req_current.random_fraction;
	end

	// Result sink: stall a drawn number of cycles per result, then hold ready high.
	always @(negedge clk) begin
		if (res_fired) begin
			res_fired = 1'b0;
			res_wait  = draw_wait();
		end
		if (res_wait > 0) begin
			res_wait--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Sample both channels at the rising edge: predict on request, check on result.
	always @(posedge clk) begin
		spin_update_t got;
		spin_update_t want;
		if (req_ch.valid && req_ch.ready) begin
			expected_updates.push_back(predict_update(req_current));
			req_fired = 1'b1;
		end
		if (res_ch.valid && res_ch.ready) begin
			res_fired = 1'b1;
			got.flip_taken        = res_ch.flip_taken;
			got.energy_total      = res_ch.energy_total;
			got.magnetization_abs = res_ch.magnetization_abs;
			if (expected_updates.size() == 0) begin
				$error("result with no request outstanding: flip_taken %0d energy_total %0d",
					got.flip_taken, $signed(got.energy_total));
				fail_count++;
			end else begin
				want = expected_updates.pop_front();
				if (got.flip_taken !== want.flip_taken) begin
					$error("flip_taken: expected %0d, actual %0d", want.flip_taken, got.flip_taken);
					fail_count++;
				end
				if (got.energy_total !== want.energy_total) begin
					$error("energy_total: expected %0d, actual %0d",
						$signed(want.energy_total), $signed(got.energy_total));
					fail_count++;
				end
				if (got.magnetization_abs !== want.magnetization_abs) begin
					$error("magnetization_abs: expected %0d, actual %0d",
						want.magnetization_abs, got.magnetization_abs);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transaction on either data channel.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_LOAD;
		req_ch.site_index      = '0;
		req_ch.spin_value      = 1'b0;
		req_ch.random_fraction = '0;
		res_ch.ready     = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.reg_index = REG_TH_DE4;
		cfg_ch.wdata     = '0;
		req_current      = '0;
		req_loaded       = 1'b0;
		req_fired        = 1'b0;
		req_gap          = 0;
		res_fired        = 1'b0;
		res_wait         = 0;
		idle_off         = 1'b0;
		fail_count       = 0;
		quiet_cycles     = 0;

		// Shadow state at reset: all spins up, thresholds zero.
		for (int s = 0; s < SITE_COUNT; s++)
			lattice_model[s] = 1'b1;
		energy_model     = -2 * SITE_COUNT;
		spin_total_model = SITE_COUNT;
		th_de4_model     = '0;
		th_de8_model     = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset thresholds: uphill flips never taken. Site 0 neighbors are 1, 64, 63, 4032.
		push_request(REQ_TRIAL, 12'd0, 1'b0, 32'h0000_0000);    // dE 8, zero threshold
		push_request(REQ_TRIAL, 12'd4095, 1'b1, 32'hFFFF_FFFF);
		push_request(REQ_LOAD, 12'd0, 1'b1, 32'h0000_0000);     // load of an equal spin
		push_request(REQ_LOAD, 12'd0, 1'b0, 32'hFFFF_FFFF);     // forced flip, rnd ignored
		push_request(REQ_TRIAL, 12'd0, 1'b1, 32'hFFFF_FFFF);    // dE -8
		push_request(REQ_LOAD, 12'd1, 1'b0, 32'h1234_5678);
		push_request(REQ_LOAD, 12'd64, 1'b0, 32'h0000_0000);
		push_request(REQ_TRIAL, 12'd0, 1'b0, 32'hFFFF_FFFF);    // dE 0
		push_request(REQ_TRIAL, 12'd0, 1'b0, 32'hFFFF_FFFF);    // dE 0 from below
		push_request(REQ_LOAD, 12'd63, 1'b0, 32'h0000_0000);
		push_request(REQ_TRIAL, 12'd0, 1'b0, 32'hFFFF_FFFF);    // dE -4
		push_request(REQ_TRIAL, 12'd0, 1'b0, 32'h0000_0000);    // dE 4, zero threshold

		// Mid thresholds; unused indexes must leave them alone.
		drain_and_settle();
		write_register(REG_TH_DE4, 32'h8000_0000);
		write_register(REG_TH_DE8, 32'h8000_0000);
		write_register(REG_UNUSED_LO, 32'hFFFF_FFFF);
		write_register(REG_UNUSED_HI, 32'h0000_0000);
		push_request(REQ_TRIAL, 12'd2080, 1'b0, 32'h8000_0000); // dE 8, equal: refused
		push_request(REQ_TRIAL, 12'd2080, 1'b0, 32'h7FFF_FFFF); // dE 8, just below: taken
		push_request(REQ_LOAD, 12'd2080, 1'b1, 32'h0000_0000);
		push_request(REQ_LOAD, 12'd2081, 1'b0, 32'h0000_0000);
		push_request(REQ_TRIAL, 12'd2080, 1'b1, 32'h8000_0000); // dE 4, equal: refused
		push_request(REQ_TRIAL, 12'd2080, 1'b1, 32'h7FFF_FFFF); // dE 4, just below: taken
		push_request(REQ_TRIAL, 12'd4095, 1'b0, 32'h0000_0000); // corner, wraps both axes
		push_request(REQ_LOAD, 12'd4032, 1'b0, 32'h0000_0000);
		push_request(REQ_TRIAL, 12'd4095, 1'b0, 32'hFFFF_FFFF);

		// Random phases over a spread of temperatures, extremes included.
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 250, 1'b0);  // infinite temperature
		run_phase(32'd736760000, 32'd126400000, 250, 1'b1);  // near the critical point
		run_phase(32'd298500000, 32'd20740000, 250, 1'b0);   // ordered phase
		run_phase(32'hFFFF_FFFF, 32'h0000_0000, 250, 1'b0);
		run_phase(32'h0000_0000, 32'hFFFF_FFFF, 250, 1'b1);
		run_phase($urandom, $urandom, 250, 1'b0);
		run_phase(32'h0000_0000, 32'h0000_0000, 230, 1'b0);  // zero temperature

		drain_and_settle();
		if (fail_count == 0 && expected_updates.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
